// ----- hw/rtl/mdvrt_pkg.sv -----
// Shared types, codes and constants for the mesh route table.
package mdvrt_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int IDX_MAX_W     = 8;
   localparam int MS_PER_S      = 1000;
   localparam int LIFE_MS_W     = 26;

   localparam logic [1:0] KIND_ADV   = 2'd0;
   localparam logic [1:0] KIND_NEXT  = 2'd1;
   localparam logic [1:0] KIND_ROLE  = 2'd2;
   localparam logic [1:0] KIND_SWEEP = 2'd3;

   localparam logic [2:0] STAT_OK      = 3'd0;
   localparam logic [2:0] STAT_LOCAL   = 3'd1;
   localparam logic [2:0] STAT_ADDED   = 3'd2;
   localparam logic [2:0] STAT_FULL    = 3'd3;
   localparam logic [2:0] STAT_TOOHIGH = 3'd4;
   localparam logic [2:0] STAT_BETTER  = 3'd5;
   localparam logic [2:0] STAT_REFRESH = 3'd6;
   localparam logic [2:0] STAT_WORSE   = 3'd7;

   localparam logic [2:0] REG_LOCAL_ADDR = 3'd0;
   localparam logic [2:0] REG_LIFETIME   = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [15:0] addr;
      logic [15:0] via;
      logic [7:0]  metric;
      logic [7:0]  role;
      logic [31:0] broker;
      logic [15:0] link;
      logic [31:0] expiry;
   } entry_type;

   typedef struct packed {
      logic                 we;
      logic [IDX_MAX_W-1:0] idx;
      entry_type            data;
   } mem_wr_type;

endpackage

// ----- hw/rtl/mdvrt_ifs.sv -----
// Request and response channel interfaces of the mesh route table.
interface mdvrt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] sender;
   logic [15:0] node_address;
   logic [7:0]  advertised_metric;
   logic [7:0]  node_role;
   logic [31:0] broker_address;
   logic [15:0] link_id;
   logic [31:0] now_ms;
   modport source (output valid, kind, sender, node_address, advertised_metric, node_role,
                   broker_address, link_id, now_ms, input ready);
   modport sink (input valid, kind, sender, node_address, advertised_metric, node_role,
                 broker_address, link_id, now_ms, output ready);
endinterface

interface mdvrt_rsp_if #(parameter int CNT_W = 7);
   logic             valid;
   logic             ready;
   logic [2:0]       status;
   logic             found;
   logic [15:0]      out_address;
   logic [15:0]      out_via;
   logic [7:0]       out_metric;
   logic [7:0]       out_role;
   logic [31:0]      out_broker;
   logic [15:0]      out_link_id;
   logic [CNT_W-1:0] entry_count;
   modport source (output valid, status, found, out_address, out_via, out_metric, out_role,
                   out_broker, out_link_id, entry_count, input ready);
   modport sink (input valid, status, found, out_address, out_via, out_metric, out_role,
                 out_broker, out_link_id, entry_count, output ready);
endinterface

// ----- hw/rtl/mesh_distance_vector_route_table.sv -----
// Top level of the mesh distance-vector route table.
//
// req_bus carries one item per beat: an advertisement entry, a next-hop
// lookup, a best-by-role lookup or an expiry sweep. rsp_bus returns exactly
// one beat per item, with status, the matched entry and the entry count.
// The csr_ port is an APB-style slave holding local_address (byte 0) and
// route_lifetime_s (byte 4); write them only while the block is idle.
// From accept to the result register, the sequencer reads one entry per
// cycle through the memory's registered read port, drains the last read,
// makes the decision and update write in ST_DECIDE and loads the result
// in ST_RESP. The next item can be accepted in the cycle after that load.
// At most one item is in flight; req_bus.ready is high only while the
// sequencer is idle. A new item is accepted while the previous result
// still waits on rsp_bus; a stalled receiver holds the beat and the next
// result waits behind it. Reset empties the table (entry count zero), sets
// the lifetime to 120 s and the local address to zero; it takes effect on
// the next clock edge.
module mesh_distance_vector_route_table #(
   parameter int TABLE_DEPTH = mdvrt_pkg::DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   mdvrt_req_if.sink            req_bus,
   mdvrt_rsp_if.source          rsp_bus,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);
   import mdvrt_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   logic [15:0]       local_ff, local_in;
   logic [15:0]       life_ff, life_in;
   logic              csr_wr;
   mem_wr_type        mem_wr;
   logic [IDX_W-1:0]  mem_rd_idx;
   entry_type         mem_rd_data;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      local_in = local_ff;
      life_in  = life_ff;
      if (csr_wr && csr_paddr == REG_LOCAL_ADDR) begin
         local_in = csr_pwdata[15:0];
      end
      if (csr_wr && csr_paddr == REG_LIFETIME) begin
         life_in = csr_pwdata[15:0];
      end
      case (csr_paddr)
         REG_LOCAL_ADDR: csr_prdata = {16'd0, local_ff};
         REG_LIFETIME:   csr_prdata = {16'd0, life_ff};
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_ff <= '0;
         life_ff  <= 16'd120;
      end else begin
         local_ff <= local_in;
         life_ff  <= life_in;
      end
   end

   mdvrt_mem #(.TABLE_DEPTH(TABLE_DEPTH)) u_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_idx  (mem_rd_idx),
      .rd_data (mem_rd_data)
   );

   mdvrt_seq #(.TABLE_DEPTH(TABLE_DEPTH)) u_seq (
      .clock            (clock),
      .reset            (reset),
      .local_address    (local_ff),
      .route_lifetime_s (life_ff),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .mem_wr           (mem_wr),
      .mem_rd_idx       (mem_rd_idx),
      .mem_rd_data      (mem_rd_data)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (32'(rsp_bus.entry_count) <= TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("ready while an item is in work");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready |-> !mem_wr.we)
      else $error("table written while idle");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("response beat right after reset");
endmodule

// ----- hw/rtl/mdvrt_mem.sv -----
// Route entry memory: one write port, one registered read port.
module mdvrt_mem #(
   parameter int TABLE_DEPTH = mdvrt_pkg::DEPTH_DEFAULT
) (
   input  logic                                   clock,
   input  mdvrt_pkg::mem_wr_type                  wr,
   input  logic [$clog2(TABLE_DEPTH)-1:0]         rd_idx,
   output mdvrt_pkg::entry_type                   rd_data
);
   import mdvrt_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.idx[IDX_W-1:0]] <= wr.data;
      end
      rd_data_ff <= mem[rd_idx];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- hw/rtl/mdvrt_seq.sv -----
// Sequencer: scans the table one entry a cycle, then updates and answers.
module mdvrt_seq #(
   parameter int TABLE_DEPTH = mdvrt_pkg::DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [15:0]                    local_address,
   input  logic [15:0]                    route_lifetime_s,
   mdvrt_req_if.sink                      req_bus,
   mdvrt_rsp_if.source                    rsp_bus,
   output mdvrt_pkg::mem_wr_type          mem_wr,
   output logic [$clog2(TABLE_DEPTH)-1:0] mem_rd_idx,
   input  mdvrt_pkg::entry_type           mem_rd_data
);
   import mdvrt_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(TABLE_DEPTH);

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     used_ff, used_in;
   logic [CNT_W-1:0]     rd_ff, rd_in;
   logic [CNT_W-1:0]     wp_ff, wp_in;
   logic                 pend_ff, pend_in;
   logic [IDX_W-1:0]     pidx_ff, pidx_in;
   logic                 hit_ff, hit_in;
   logic [IDX_W-1:0]     hidx_ff, hidx_in;
   entry_type            hent_ff, hent_in;
   logic [7:0]           maxm_ff, maxm_in;
   logic [1:0]           kind_ff;
   logic [15:0]          sender_ff, addr_ff, link_ff;
   logic [7:0]           metric_ff, role_ff;
   logic [31:0]          broker_ff, now_ff;
   logic [LIFE_MS_W-1:0] life_ms_ff;
   logic [2:0]           res_status_ff, res_status_in;
   logic                 res_found_ff, res_found_in;
   entry_type            res_ent_ff, res_ent_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           rsp_status_ff;
   logic                 rsp_found_ff;
   entry_type            rsp_ent_ff;
   logic [CNT_W-1:0]     rsp_count_ff;
   logic                 accept, load_rsp;
   logic [31:0]          new_expiry;
   entry_type            upd;

   assign accept     = req_bus.valid && req_bus.ready;
   assign new_expiry = now_ff + 32'(life_ms_ff);
   assign mem_rd_idx = rd_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff         <= rd_in;
      wp_ff         <= wp_in;
      pidx_ff       <= pidx_in;
      hit_ff        <= hit_in;
      hidx_ff       <= hidx_in;
      hent_ff       <= hent_in;
      maxm_ff       <= maxm_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_ent_ff    <= res_ent_in;
      if (accept) begin
         kind_ff    <= req_bus.kind;
         sender_ff  <= req_bus.sender;
         addr_ff    <= req_bus.node_address;
         metric_ff  <= (req_bus.advertised_metric == 8'hFF) ? 8'hFF
                       : req_bus.advertised_metric + 8'd1;
         role_ff    <= req_bus.node_role;
         broker_ff  <= req_bus.broker_address;
         link_ff    <= req_bus.link_id;
         now_ff     <= req_bus.now_ms;
         life_ms_ff <= LIFE_MS_W'(route_lifetime_s) * LIFE_MS_W'(MS_PER_S);
      end
      if (load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_found_ff  <= res_found_ff;
         rsp_ent_ff    <= res_ent_ff;
         rsp_count_ff  <= used_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      rd_in         = rd_ff;
      wp_in         = wp_ff;
      pend_in       = 1'b0;
      pidx_in       = pidx_ff;
      hit_in        = hit_ff;
      hidx_in       = hidx_ff;
      hent_in       = hent_ff;
      maxm_in       = maxm_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_ent_in    = res_ent_ff;
      mem_wr        = '0;
      load_rsp      = 1'b0;
      upd           = hent_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      req_bus.ready = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rd_in    = '0;
               wp_in    = '0;
               hit_in   = 1'b0;
               maxm_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_ff < used_ff) begin
               rd_in   = rd_ff + CNT_W'(1);
               pend_in = 1'b1;
               pidx_in = rd_ff[IDX_W-1:0];
            end else if (!pend_ff) begin
               state_in = ST_DECIDE;
            end
            if (pend_ff) begin
               if (mem_rd_data.metric > maxm_ff) begin
                  maxm_in = mem_rd_data.metric;
               end
               case (kind_ff)
                  KIND_ADV, KIND_NEXT: begin
                     if (!hit_ff && mem_rd_data.addr == addr_ff) begin
                        hit_in  = 1'b1;
                        hidx_in = pidx_ff;
                        hent_in = mem_rd_data;
                     end
                  end
                  KIND_ROLE: begin
                     if ((mem_rd_data.role & role_ff) == role_ff
                         && (!hit_ff || mem_rd_data.metric < hent_ff.metric)) begin
                        hit_in  = 1'b1;
                        hidx_in = pidx_ff;
                        hent_in = mem_rd_data;
                     end
                  end
                  default: begin
                     if (!(mem_rd_data.expiry < now_ff)) begin
                        mem_wr.we   = 1'b1;
                        mem_wr.idx  = IDX_MAX_W'(wp_ff[IDX_W-1:0]);
                        mem_wr.data = mem_rd_data;
                        wp_in       = wp_ff + CNT_W'(1);
                     end
                  end
               endcase
            end
         end
         ST_DECIDE: begin
            res_status_in = STAT_OK;
            res_found_in  = 1'b0;
            res_ent_in    = '0;
            case (kind_ff)
               KIND_ADV: begin
                  if (addr_ff == local_address) begin
                     res_status_in = STAT_LOCAL;
                  end else if (hit_ff) begin
                     if (metric_ff < hent_ff.metric) begin
                        upd.metric    = metric_ff;
                        upd.via       = sender_ff;
                        upd.expiry    = new_expiry;
                        upd.broker    = broker_ff;
                        res_status_in = STAT_BETTER;
                     end else if (metric_ff == hent_ff.metric) begin
                        upd.expiry    = new_expiry;
                        res_status_in = STAT_REFRESH;
                     end else begin
                        res_status_in = STAT_WORSE;
                     end
                     if (upd.via == sender_ff) begin
                        upd.role   = role_ff;
                        upd.broker = broker_ff;
                        upd.link   = link_ff;
                     end
                     mem_wr.we   = 1'b1;
                     mem_wr.idx  = IDX_MAX_W'(hidx_ff);
                     mem_wr.data = upd;
                  end else if (used_ff >= FULL) begin
                     res_status_in = STAT_FULL;
                  end else if ({1'b0, metric_ff} > {1'b0, maxm_ff} + 9'd1) begin
                     res_status_in = STAT_TOOHIGH;
                  end else begin
                     mem_wr.we          = 1'b1;
                     mem_wr.idx         = IDX_MAX_W'(used_ff[IDX_W-1:0]);
                     mem_wr.data.addr   = addr_ff;
                     mem_wr.data.via    = sender_ff;
                     mem_wr.data.metric = metric_ff;
                     mem_wr.data.role   = role_ff;
                     mem_wr.data.broker = broker_ff;
                     mem_wr.data.link   = link_ff;
                     mem_wr.data.expiry = new_expiry;
                     used_in            = used_ff + CNT_W'(1);
                     res_status_in      = STAT_ADDED;
                  end
               end
               KIND_NEXT, KIND_ROLE: begin
                  res_found_in = hit_ff;
                  res_ent_in   = hit_ff ? hent_ff : '0;
               end
               default: begin
                  used_in = wp_ff;
               end
            endcase
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.found       = rsp_found_ff;
   assign rsp_bus.out_address = rsp_ent_ff.addr;
   assign rsp_bus.out_via     = rsp_ent_ff.via;
   assign rsp_bus.out_metric  = rsp_ent_ff.metric;
   assign rsp_bus.out_role    = rsp_ent_ff.role;
   assign rsp_bus.out_broker  = rsp_ent_ff.broker;
   assign rsp_bus.out_link_id = rsp_ent_ff.link;
   assign rsp_bus.entry_count = rsp_count_ff;
endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the mesh distance-vector route table.
`timescale 1ns / 100ps

module testbench;
   import mdvrt_pkg::*;

   localparam int ROUTE_SLOTS   = 64;
   localparam int DRAIN_CYCLES  = 120;
   localparam int HOLD_CYCLES   = 600;
   localparam int STALL_LIMIT   = 6000;
   localparam int REPORT_MAX    = 10;

   typedef struct {
      logic [1:0]  kind;
      logic [15:0] sender;
      logic [15:0] node_address;
      logic [7:0]  advertised_metric;
      logic [7:0]  node_role;
      logic [31:0] broker_address;
      logic [15:0] link_id;
      logic [31:0] now_ms;
   } route_req_type;

   typedef struct {
      logic [2:0]  status;
      logic        found;
      logic [15:0] out_address;
      logic [15:0] out_via;
      logic [7:0]  out_metric;
      logic [7:0]  out_role;
      logic [31:0] out_broker;
      logic [15:0] out_link_id;
      logic [6:0]  entry_count;
   } route_rsp_type;

   typedef struct {
      route_req_type beat;
      bit            typed;
      route_rsp_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mdvrt_req_if req_bus();
   mdvrt_rsp_if #(.CNT_W(7)) rsp_bus();

   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   mesh_distance_vector_route_table u_top (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus.sink),
      .rsp_bus    (rsp_bus.source),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #5 clock = ~clock;

   // route table mirror
   entry_type   routes [ROUTE_SLOTS];
   int          route_count = 0;
   logic [15:0] own_address = 16'd0;
   logic [15:0] lifetime_s = 16'd120;

   route_rsp_type pending_rsp [$];
   int          mismatches = 0;
   bit          calm = 1'b0;
   bit          hold_request = 1'b0;
   int          hold_left = 0;
   int          quiet_cycles = 0;
   logic [31:0] clock_ms = '0;
   int          addr_pool = 100;
   int          addr_base = 0;

   function automatic logic [31:0] expiry_of(logic [31:0] now);
      return now + 32'(lifetime_s) * 32'(MS_PER_S);
   endfunction

   function automatic int find_route(logic [15:0] addr);
      for (int i = 0; i < route_count; i++)
         if (routes[i].addr == addr) return i;
      return -1;
   endfunction

   function automatic route_rsp_type route_predict(route_req_type r);
      route_rsp_type o;
      int idx;
      int best;
      int keep;
      int peak;
      logic [7:0] m;
      o = '{default: '0};
      o.status = STAT_OK;
      idx = -1;
      case (r.kind)
         KIND_ADV: begin
            m = (r.advertised_metric == 8'hFF) ? 8'hFF : r.advertised_metric + 8'd1;
            if (r.node_address == own_address) begin
               o.status = STAT_LOCAL;
            end else begin
               idx = find_route(r.node_address);
               if (idx < 0) begin
                  peak = 0;
                  for (int i = 0; i < route_count; i++)
                     if (int'(routes[i].metric) > peak) peak = routes[i].metric;
                  if (route_count >= ROUTE_SLOTS) begin
                     o.status = STAT_FULL;
                  end else if (int'(m) > peak + 1) begin
                     o.status = STAT_TOOHIGH;
                  end else begin
                     routes[route_count] = '{addr: r.node_address, via: r.sender, metric: m,
                        role: r.node_role, broker: r.broker_address, link: r.link_id,
                        expiry: expiry_of(r.now_ms)};
                     route_count++;
                     o.status = STAT_ADDED;
                  end
               end else begin
                  if (m < routes[idx].metric) begin
                     routes[idx].metric = m;
                     routes[idx].via = r.sender;
                     routes[idx].expiry = expiry_of(r.now_ms);
                     routes[idx].broker = r.broker_address;
                     o.status = STAT_BETTER;
                  end else if (m == routes[idx].metric) begin
                     routes[idx].expiry = expiry_of(r.now_ms);
                     o.status = STAT_REFRESH;
                  end else begin
                     o.status = STAT_WORSE;
                  end
                  if (routes[idx].via == r.sender) begin
                     routes[idx].role = r.node_role;
                     routes[idx].broker = r.broker_address;
                     routes[idx].link = r.link_id;
                  end
                  idx = -1;
               end
            end
         end
         KIND_NEXT: idx = find_route(r.node_address);
         KIND_ROLE: begin
            best = -1;
            for (int i = 0; i < route_count; i++)
               if ((routes[i].role & r.node_role) == r.node_role &&
                   (best < 0 || routes[i].metric < routes[best].metric))
                  best = i;
            idx = best;
         end
         default: begin
            keep = 0;
            for (int i = 0; i < route_count; i++) begin
               if (routes[i].expiry < r.now_ms) continue;
               routes[keep] = routes[i];
               keep++;
            end
            route_count = keep;
         end
      endcase
      if (idx >= 0) begin
         o.found = 1'b1;
         o.out_address = routes[idx].addr;
         o.out_via = routes[idx].via;
         o.out_metric = routes[idx].metric;
         o.out_role = routes[idx].role;
         o.out_broker = routes[idx].broker;
         o.out_link_id = routes[idx].link;
      end
      o.entry_count = 7'(route_count);
      return o;
   endfunction

   function automatic route_req_type mk_req(logic [1:0] kind, logic [15:0] sender,
                                            logic [15:0] addr, logic [7:0] metric,
                                            logic [7:0] role, logic [31:0] broker,
                                            logic [15:0] link, logic [31:0] now);
      route_req_type r;
      r = '{kind, sender, addr, metric, role, broker, link, now};
      return r;
   endfunction

   function automatic route_rsp_type mk_rsp(logic [2:0] status, logic [6:0] count);
      route_rsp_type o;
      o = '{default: '0};
      o.status = status;
      o.entry_count = count;
      return o;
   endfunction

   function automatic logic [15:0] pool_addr();
      return 16'(addr_base + $urandom_range(addr_pool - 1));
   endfunction

   function automatic route_req_type random_req();
      route_req_type r;
      int pick;
      r.sender = pool_addr();
      r.node_address = pool_addr();
      r.advertised_metric = 8'($urandom_range(4));
      r.node_role = 8'(1 << $urandom_range(7)) | 8'($urandom_range(3));
      r.broker_address = $urandom;
      r.link_id = 16'($urandom);
      r.now_ms = clock_ms;
      pick = $urandom_range(99);
      if (pick < 60) r.kind = KIND_ADV;
      else if (pick < 78) r.kind = KIND_NEXT;
      else if (pick < 92) r.kind = KIND_ROLE;
      else r.kind = KIND_SWEEP;
      if (r.kind == KIND_ROLE && $urandom_range(3) == 0)
         r.node_role = 8'(1 << $urandom_range(7));
      // noise gives any value to sender, address, metric, role and now_ms
      if ($urandom_range(99) < 12) begin
         r.sender = 16'($urandom);
         r.node_address = 16'($urandom);
         r.advertised_metric = 8'($urandom);
         r.node_role = 8'($urandom);
         r.now_ms = $urandom;
      end
      return r;
   endfunction

   task automatic drive_beat(route_req_type r, bit typed, route_rsp_type want);
      route_rsp_type pred;
      if (!calm && $urandom_range(99) < 38) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.kind <= r.kind;
      req_bus.sender <= r.sender;
      req_bus.node_address <= r.node_address;
      req_bus.advertised_metric <= r.advertised_metric;
      req_bus.node_role <= r.node_role;
      req_bus.broker_address <= r.broker_address;
      req_bus.link_id <= r.link_id;
      req_bus.now_ms <= r.now_ms;
      do @(posedge clock); while (!req_bus.ready);
      pred = route_predict(r);
      pending_rsp.push_back(typed ? want : pred);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == REG_LOCAL_ADDR) own_address = data[15:0];
      else if (addr == REG_LIFETIME) lifetime_s = data[15:0];
   endtask

   task automatic run_phase(int beats, logic [15:0] local_addr, logic [15:0] life,
                            int pool, int base, bit quiet, bit press);
      wait_idle();
      csr_write(REG_LOCAL_ADDR, {16'd0, local_addr});
      csr_write(REG_LIFETIME, {16'hFFFF, life});
      addr_pool = pool;
      addr_base = base;
      calm = quiet;
      for (int n = 0; n < beats; n++) begin
         if (press && n == beats / 2) hold_request = 1'b1;
         clock_ms += $urandom_range(1500);
         drive_beat(random_req(), 1'b0, mk_rsp(STAT_OK, 0));
      end
   endtask

   function automatic void compare_rsp();
      route_rsp_type w;
      bit bad;
      if (pending_rsp.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_MAX)
            $display("unexpected response beat at %0t", $realtime);
         return;
      end
      w = pending_rsp.pop_front();
      bad = rsp_bus.status !== w.status || rsp_bus.found !== w.found ||
            rsp_bus.out_address !== w.out_address || rsp_bus.out_via !== w.out_via ||
            rsp_bus.out_metric !== w.out_metric || rsp_bus.out_role !== w.out_role ||
            rsp_bus.out_broker !== w.out_broker || rsp_bus.out_link_id !== w.out_link_id ||
            rsp_bus.entry_count !== w.entry_count;
      if (bad) begin
         mismatches++;
         if (mismatches <= REPORT_MAX) begin
            $display("mismatch at %0t:", $realtime);
            $display("  exp st=%0d f=%0d a=%h v=%h m=%0d r=%h b=%h l=%h n=%0d",
               w.status, w.found, w.out_address, w.out_via, w.out_metric,
               w.out_role, w.out_broker, w.out_link_id, w.entry_count);
            $display("  got st=%0d f=%0d a=%h v=%h m=%0d r=%h b=%h l=%h n=%0d",
               rsp_bus.status, rsp_bus.found, rsp_bus.out_address, rsp_bus.out_via,
               rsp_bus.out_metric, rsp_bus.out_role, rsp_bus.out_broker,
               rsp_bus.out_link_id, rsp_bus.entry_count);
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) compare_rsp();
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_bus.ready <= 1'b0;
         end else if (hold_request) begin
            hold_request <= 1'b0;
            hold_left <= HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= calm ? 1'b1 : ($urandom_range(99) >= 38);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   stim_row_type directed [$];

   initial begin
      req_bus.valid = 1'b0;
      req_bus.kind = KIND_ADV;
      req_bus.sender = '0;
      req_bus.node_address = '0;
      req_bus.advertised_metric = '0;
      req_bus.node_role = '0;
      req_bus.broker_address = '0;
      req_bus.link_id = '0;
      req_bus.now_ms = '0;

      directed = '{
         '{mk_req(KIND_NEXT, 16'h0, 16'h1234, 8'h0, 8'h0, 32'h0, 16'h0, 32'h0), 1,
           mk_rsp(STAT_OK, 0)},
         '{mk_req(KIND_ROLE, 16'h0, 16'h0, 8'h0, 8'h00, 32'h0, 16'h0, 32'h0), 1,
           mk_rsp(STAT_OK, 0)},
         '{mk_req(KIND_SWEEP, 16'h0, 16'h0, 8'h0, 8'h0, 32'h0, 16'h0, 32'h0), 1,
           mk_rsp(STAT_OK, 0)},
         '{mk_req(KIND_ADV, 16'h7, 16'h0, 8'h0, 8'h1, 32'h1, 16'h1, 32'h0), 1,
           mk_rsp(STAT_LOCAL, 0)},
         '{mk_req(KIND_ADV, 16'h1, 16'h1, 8'h0, 8'h3, 32'h0A000001, 16'h11, 32'h0), 1,
           mk_rsp(STAT_ADDED, 1)},
         '{mk_req(KIND_ADV, 16'h1, 16'h2, 8'hFF, 8'h3, 32'h0, 16'h0, 32'h0), 1,
           mk_rsp(STAT_TOOHIGH, 1)},
         '{mk_req(KIND_ADV, 16'h1, 16'h2, 8'h0, 8'h5, 32'h0A000002, 16'h22, 32'h0), 1,
           mk_rsp(STAT_ADDED, 2)},
         '{mk_req(KIND_ADV, 16'h3, 16'h2, 8'h0, 8'h1, 32'h0A000003, 16'h33, 32'd10), 0,
           mk_rsp(STAT_OK, 0)},
         '{mk_req(KIND_ADV, 16'h3, 16'h2, 8'h0, 8'hFF, 32'hFFFFFFFF, 16'hFFFF, 32'd20), 0,
           mk_rsp(STAT_OK, 0)},
         '{mk_req(KIND_ADV, 16'h9, 16'h2, 8'h5, 8'h0, 32'h0, 16'h0, 32'd30), 0,
           mk_rsp(STAT_OK, 0)},
         '{mk_req(KIND_ADV, 16'hFFFF, 16'h3, 8'h1, 8'h80, 32'h0, 16'h0, 32'd40), 0,
           mk_rsp(STAT_OK, 0)},
         '{mk_req(KIND_ADV, 16'hFFFF, 16'hFFFF, 8'h0, 8'h80, 32'h80000000, 16'h8000,
           32'hFFFFFFFF), 0, mk_rsp(STAT_OK, 0)},
         '{mk_req(KIND_NEXT, 16'h0, 16'h2, 8'h0, 8'h0, 32'h0, 16'h0, 32'h0), 0,
           mk_rsp(STAT_OK, 0)},
         '{mk_req(KIND_ROLE, 16'h0, 16'h0, 8'h0, 8'h00, 32'h0, 16'h0, 32'h0), 0,
           mk_rsp(STAT_OK, 0)},
         '{mk_req(KIND_ROLE, 16'h0, 16'h0, 8'h0, 8'hFF, 32'h0, 16'h0, 32'h0), 0,
           mk_rsp(STAT_OK, 0)},
         '{mk_req(KIND_ROLE, 16'h0, 16'h0, 8'h0, 8'h80, 32'h0, 16'h0, 32'h0), 0,
           mk_rsp(STAT_OK, 0)},
         '{mk_req(KIND_SWEEP, 16'h0, 16'h0, 8'h0, 8'h0, 32'h0, 16'h0, 32'd120001), 0,
           mk_rsp(STAT_OK, 0)},
         '{mk_req(KIND_NEXT, 16'h0, 16'h1, 8'h0, 8'h0, 32'h0, 16'h0, 32'h0), 0,
           mk_rsp(STAT_OK, 0)},
         '{mk_req(KIND_SWEEP, 16'h0, 16'h0, 8'h0, 8'h0, 32'h0, 16'h0, 32'hFFFFFFFF), 0,
           mk_rsp(STAT_OK, 0)}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) drive_beat(directed[i].beat, directed[i].typed, directed[i].want);

      run_phase(190, 16'h0005, 16'd120, 100, 0, 1'b1, 1'b0);
      run_phase(190, 16'hFFFF, 16'd0, 40, 16'hFFE0, 1'b0, 1'b1);
      run_phase(190, 16'h0000, 16'd2, 70, 0, 1'b0, 1'b0);
      run_phase(190, 16'h1234, 16'hFFFF, 100, 16'h1200, 1'b0, 1'b0);
      clock_ms = 32'hFFFF_0000;
      run_phase(190, 16'hA5A5, 16'd1, 60, 16'hA590, 1'b0, 1'b1);
      run_phase(190, 16'h5A5A, 16'd30, 90, 16'h5A20, 1'b0, 1'b0);

      wait_idle();
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
